@@ rtl/sss_pkg.sv @@
package sss_pkg;

   localparam int DEF_MAX_STACKS   = 16;
   localparam int DEF_MAX_CAPACITY = 16;

   localparam int CMD_W    = 2;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 8;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 5;

   localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POP_AT = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

   localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
   localparam logic [VALUE_W-1:0] MINUS_ONE = '1;

   typedef enum logic {
      SSS_IDLE,
      SSS_READ
   } sss_state_type;

   // what the control stage records for the word that is in flight
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                from_ram;
   } sss_pend_type;

endpackage

@@ rtl/sss_plate_ram.sv @@
module sss_plate_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           addr,
   input  logic [sss_pkg::VALUE_W-1:0] wr_data,
   output logic [sss_pkg::VALUE_W-1:0] rd_data
);
   import sss_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sss_ctrl.sv @@
module sss_ctrl #(
   parameter int MAX_STACKS   = 16,
   parameter int MAX_CAPACITY = 16,
   parameter int ADDR_W       = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sss_pkg::CAP_W-1:0]     capacity,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sss_pkg::CMD_W-1:0]     req_command,
   input  logic [sss_pkg::VALUE_W-1:0]   req_push_value,
   input  logic [sss_pkg::INDEX_W-1:0]   req_stack_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sss_pkg::VALUE_W-1:0]   rsp_pop_value,
   output logic [sss_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          ram_wr_en,
   output logic                          ram_rd_en,
   output logic [ADDR_W-1:0]             ram_addr,
   output logic [sss_pkg::VALUE_W-1:0]   ram_wr_data,
   input  logic [sss_pkg::VALUE_W-1:0]   ram_rd_data
);
   import sss_pkg::*;

   localparam int SLOT_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
   localparam int USE_W  = $clog2(MAX_STACKS + 1);
   localparam int CNT_W  = $clog2(MAX_CAPACITY + 1);
   localparam int EW     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int CMP_W  = (USE_W > INDEX_W) ? USE_W : INDEX_W;

   sss_state_type      state_ff, state_in;
   sss_pend_type       pend_ff, pend_in;
   logic [SLOT_W-1:0]  order_ff [MAX_STACKS];
   logic [SLOT_W-1:0]  order_in [MAX_STACKS];
   logic [CNT_W-1:0]   fill_ff  [MAX_STACKS];
   logic [CNT_W-1:0]   fill_in  [MAX_STACKS];
   logic [USE_W-1:0]   in_use_ff, in_use_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic               accept;
   logic               out_free;
   logic [EW-1:0]      eff_cap;
   logic [SLOT_W-1:0]  last_phys;
   logic [SLOT_W-1:0]  next_phys;
   logic               need_new;
   logic [USE_W-1:0]   pop_k;
   logic               pop_ok;
   logic [SLOT_W-1:0]  phys;
   logic [CNT_W-1:0]   base_fill;
   logic [CNT_W-1:0]   new_fill;
   logic [CMP_W-1:0]   idx_ext;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign idx_ext  = CMP_W'(req_stack_index);

   always_comb begin
      if (EW'(capacity) > EW'(MAX_CAPACITY)) begin
         eff_cap = EW'(MAX_CAPACITY);
      end else begin
         eff_cap = EW'(capacity);
      end
   end

   assign last_phys = order_ff[SLOT_W'(in_use_ff - USE_W'(1))];
   assign next_phys = order_ff[in_use_ff[SLOT_W-1:0]];
   assign need_new  = (in_use_ff == '0) || (EW'(fill_ff[last_phys]) >= eff_cap);

   always_comb begin
      if (req_command == CMD_POP) begin
         pop_k  = in_use_ff - USE_W'(1);
         pop_ok = (in_use_ff != '0);
      end else begin
         pop_k  = USE_W'(req_stack_index);
         pop_ok = (idx_ext < CMP_W'(in_use_ff));
      end
   end

   always_comb begin
      state_in      = state_ff;
      pend_in       = pend_ff;
      order_in      = order_ff;
      fill_in       = fill_ff;
      in_use_in     = in_use_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      phys          = last_phys;
      base_fill     = '0;
      new_fill      = '0;
      req_ready     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         SSS_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               state_in = SSS_READ;
               pend_in  = '{status: ST_EMPTY, from_ram: 1'b0};
               case (req_command)
                  CMD_PUSH: begin
                     phys      = need_new ? next_phys : last_phys;
                     base_fill = need_new ? '0 : fill_ff[last_phys];
                     new_fill  = base_fill + CNT_W'(1);
                     if (eff_cap == '0) begin
                        pend_in.status = ST_IGNORED;
                     end else if (need_new && (in_use_ff == USE_W'(MAX_STACKS))) begin
                        pend_in.status = ST_FULL;
                     end else begin
                        pend_in.status = ST_OK;
                        ram_wr_en      = 1'b1;
                        fill_in[phys]  = new_fill;
                        if (need_new) begin
                           in_use_in = in_use_ff + USE_W'(1);
                        end
                     end
                  end
                  CMD_POP, CMD_POP_AT: begin
                     phys      = order_ff[pop_k[SLOT_W-1:0]];
                     base_fill = fill_ff[phys] - CNT_W'(1);
                     if (pop_ok) begin
                        pend_in       = '{status: ST_OK, from_ram: 1'b1};
                        ram_rd_en     = 1'b1;
                        fill_in[phys] = base_fill;
                        if (base_fill == '0) begin
                           // close the gap and park the emptied slot at the end
                           for (int j = 0; j < MAX_STACKS; j++) begin
                              if ((USE_W'(j) >= pop_k) &&
                                  (USE_W'(j) + USE_W'(1) < in_use_ff)) begin
                                 order_in[j] = order_ff[(j + 1) % MAX_STACKS];
                              end
                              if (USE_W'(j) + USE_W'(1) == in_use_ff) begin
                                 order_in[j] = phys;
                              end
                           end
                           in_use_in = in_use_ff - USE_W'(1);
                        end
                     end
                  end
                  default: begin
                     pend_in = '{status: ST_EMPTY, from_ram: 1'b0};
                  end
               endcase
            end
         end
         SSS_READ: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = pend_ff.from_ram ? ram_rd_data : MINUS_ONE;
               rsp_status_in = pend_ff.status;
               state_in      = SSS_IDLE;
            end
         end
         default: begin
            state_in = SSS_IDLE;
         end
      endcase
   end

   assign ram_addr    = ADDR_W'(ADDR_W'(phys) * ADDR_W'(MAX_CAPACITY) + ADDR_W'(base_fill));
   assign ram_wr_data = req_push_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SSS_IDLE;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_STACKS; i++) begin
            order_ff[i] <= SLOT_W'(i);
            fill_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
         order_ff     <= order_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff       <= pend_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pop_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

@@ rtl/segmented_stack_set_top.sv @@
// result: an accepted word moves the control to its read state, which registers the
// result once the output register is free; a waiting result can hold it there
// one word at a time: no new word is taken while the read state holds the last one;
// the plate ram read of a pop and the table update are issued as a word is accepted
// a waiting result lets one more word in; further words wait until it leaves
// reset (synchronous): no stacks open, identity slot order, capacity 16; the
// plate ram is not cleared
module segmented_stack_set_top #(
   parameter int MAX_STACKS   = sss_pkg::DEF_MAX_STACKS,
   parameter int MAX_CAPACITY = sss_pkg::DEF_MAX_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sss_pkg::CAP_W-1:0]           csr_capacity,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sss_pkg::CMD_W-1:0]           req_command,
   input  logic signed [sss_pkg::VALUE_W-1:0]  req_push_value,
   input  logic [sss_pkg::INDEX_W-1:0]         req_stack_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [sss_pkg::VALUE_W-1:0]  rsp_pop_value,
   output logic [sss_pkg::STATUS_W-1:0]        rsp_status
);
   import sss_pkg::*;

   localparam int DEPTH  = MAX_STACKS * MAX_CAPACITY;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CAP_W-1:0]   capacity_ff;
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_addr;
   logic [VALUE_W-1:0] ram_wr_data;
   logic [VALUE_W-1:0] ram_rd_data;
   logic [VALUE_W-1:0] pop_value;

   // capacity only changes with nothing in flight
   assign csr_ready = req_ready && !rsp_valid && !req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_capacity;
      end
   end

   sss_ctrl #(
      .MAX_STACKS   (MAX_STACKS),
      .MAX_CAPACITY (MAX_CAPACITY),
      .ADDR_W       (ADDR_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .capacity        (capacity_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_push_value  (req_push_value),
      .req_stack_index (req_stack_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pop_value   (pop_value),
      .rsp_status      (rsp_status),
      .ram_wr_en       (ram_wr_en),
      .ram_rd_en       (ram_rd_en),
      .ram_addr        (ram_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_data     (ram_rd_data)
   );

   sss_plate_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_plate_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   assign rsp_pop_value = pop_value;

   // an accepted word is followed by the read state, in which no new word is taken
   a_interlock: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("word accepted while the previous one is in flight");

   // only a successful pop carries a value other than minus one
   a_fail_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_pop_value == MINUS_ONE))
      else $error("failed word returns a value");

   a_ignored_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_IGNORED) |-> (capacity_ff == '0))
      else $error("push ignored with nonzero capacity");

endmodule
